### hw/rtl/two_digit_segment_display_driver_unit_assert.svh
// assertion macros shared by the display driver modules
// each use expects clk and rst in scope of the including module
`ifndef TWO_DIGIT_SEGMENT_DISPLAY_DRIVER_UNIT_ASSERT_SVH
`define TWO_DIGIT_SEGMENT_DISPLAY_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define TDSD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TDSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tdsd_pkg.sv
// types, operation codes and segment maps for the two-digit display driver
// no dependencies
package tdsd_pkg;

  localparam logic [1:0] OP_SHOW  = 2'd0;
  localparam logic [1:0] OP_BLANK = 2'd1;
  localparam logic [1:0] OP_UDOT  = 2'd2;
  localparam logic [1:0] OP_TDOT  = 2'd3;

  localparam logic [7:0] UNITS_DOT = 8'h10;
  localparam logic [7:0] TENS_DOT  = 8'h02;
  localparam logic [6:0] MAX_SHOWN = 7'd99;

  // divide by ten as multiply by 205 then shift by 11, exact for 0..99
  localparam logic [7:0] DIV10_MUL = 8'd205;
  localparam int DIV10_SHIFT = 11;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [3:0] LAST_BIT = 4'd15;

  typedef logic [7:0] seg_byte_t;

  typedef struct packed {
    seg_byte_t tens;
    seg_byte_t units;
  } seg_word_t;

  function automatic seg_byte_t units_map(input logic [3:0] d);
    seg_byte_t s;
    unique case (d)
      4'd0:    s = 8'hED;
      4'd1:    s = 8'h28;
      4'd2:    s = 8'hCE;
      4'd3:    s = 8'hAE;
      4'd4:    s = 8'h2B;
      4'd5:    s = 8'hA7;
      4'd6:    s = 8'hE7;
      4'd7:    s = 8'h2C;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hAF;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic seg_byte_t tens_map(input logic [3:0] d);
    seg_byte_t s;
    unique case (d)
      4'd0:    s = 8'hED;
      4'd1:    s = 8'h41;
      4'd2:    s = 8'hDC;
      4'd3:    s = 8'hD5;
      4'd4:    s = 8'h71;
      4'd5:    s = 8'hB5;
      4'd6:    s = 8'hBD;
      4'd7:    s = 8'hC1;
      4'd8:    s = 8'hFD;
      4'd9:    s = 8'hF5;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/tdsd_front.sv
// front end: accepts operations, keeps the segment bytes and the blanking mode
// depends on tdsd_pkg
module tdsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_tuser,
  input  logic [7:0]        s_tdata,
  output logic              push,
  output tdsd_pkg::seg_word_t push_word,
  input  logic              q_room
);
  import tdsd_pkg::*;

  logic       blank_leading_zero;
  seg_byte_t  units_seg;
  seg_byte_t  tens_seg;
  seg_byte_t  units_next;
  seg_byte_t  tens_next;
  logic [6:0] value;
  logic       dot_on;
  logic [6:0] val_sat;
  logic [14:0] prod;
  logic [3:0] tens_d;
  logic [6:0] units_w;
  logic [3:0] units_d;
  seg_byte_t  udot;
  seg_byte_t  tdot;

  assign value  = s_tdata[6:0];
  assign dot_on = s_tdata[7];

  assign val_sat = (value > MAX_SHOWN) ? MAX_SHOWN : value;
  assign prod    = 15'(val_sat) * 15'(DIV10_MUL);
  assign tens_d  = prod[DIV10_SHIFT +: 4];
  assign units_w = val_sat - {tens_d, 3'b000} - {2'b00, tens_d, 1'b0};
  assign units_d = units_w[3:0];

  assign udot = units_seg & UNITS_DOT;
  assign tdot = tens_seg & TENS_DOT;

  always_comb begin
    units_next = units_seg;
    tens_next  = tens_seg;
    unique case (s_tuser)
      OP_SHOW: begin
        units_next = units_map(units_d) | udot;
        if (blank_leading_zero && (tens_d == 4'd0)) begin
          tens_next = tdot;
        end else begin
          tens_next = tens_map(tens_d) | tdot;
        end
      end
      OP_BLANK: begin
        units_next = udot;
        tens_next  = tdot;
      end
      OP_UDOT: begin
        units_next = dot_on ? (units_seg | UNITS_DOT) : (units_seg & ~UNITS_DOT);
      end
      OP_TDOT: begin
        tens_next = dot_on ? (tens_seg | TENS_DOT) : (tens_seg & ~TENS_DOT);
      end
      default: begin
        units_next = units_seg;
        tens_next  = tens_seg;
      end
    endcase
  end

  assign s_tready        = q_room;
  assign push            = s_tvalid && q_room;
  assign push_word.tens  = tens_next;
  assign push_word.units = units_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_leading_zero <= 1'b0;
      units_seg          <= '0;
      tens_seg           <= '0;
    end else begin
      if (cfg_wen) begin
        blank_leading_zero <= cfg_wdata;
      end
      if (push) begin
        units_seg <= units_next;
        tens_seg  <= tens_next;
      end
    end
  end

endmodule

### hw/rtl/tdsd_queue.sv
// two-entry queue of segment words between the front end and the shifter
// depends on tdsd_pkg and the assertion macro header
`include "two_digit_segment_display_driver_unit_assert.svh"
module tdsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tdsd_pkg::seg_word_t push_word,
  output logic              q_room,
  input  logic              pop,
  output logic              q_valid,
  output tdsd_pkg::seg_word_t head
);
  import tdsd_pkg::*;

  seg_word_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign q_room  = (count != Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TDSD_ASSERT_IMPL(a_no_push_full, push, count != Q_CNT_W'(Q_DEPTH), "push into full queue")
  `TDSD_ASSERT_IMPL(a_no_pop_empty, pop, count != '0, "pop from empty queue")
  `TDSD_ASSERT_NEXT(a_empty_holds, (count == '0) && !push, count == '0, "queue filled with no push")

endmodule

### hw/rtl/tdsd_shifter.sv
// back end: shifts each segment word out msb first with the latch mark on the last bit
// depends on tdsd_pkg and the assertion macro header
`include "two_digit_segment_display_driver_unit_assert.svh"
module tdsd_shifter (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tdsd_pkg::seg_word_t head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic              out_bit,
  output logic              m_tlast
);
  import tdsd_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] shreg;
  logic        advance;

  // output register may be refilled when empty or being taken
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        m_tvalid <= 1'b1;
        m_tlast  <= (cnt == LAST_BIT);
        cnt      <= cnt + 1'b1;
        busy     <= (cnt != LAST_BIT);
      end else if (q_valid) begin
        // first bit goes straight from the queue head
        m_tvalid <= 1'b1;
        m_tlast  <= 1'b0;
        cnt      <= 4'd1;
        busy     <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
        m_tlast  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        out_bit <= shreg[15];
        shreg   <= {shreg[14:0], 1'b0};
      end else if (q_valid) begin
        out_bit <= head[15];
        shreg   <= {head[14:0], 1'b0};
      end
    end
  end

  `TDSD_ASSERT_IMPL(a_cnt_live, busy, cnt != '0, "bit counter zero while shifting")
  `TDSD_ASSERT_NEXT(a_last_ends, advance && busy && (cnt == LAST_BIT), !busy && m_tlast,
                    "word did not end on the sixteenth bit")
  `TDSD_ASSERT_IMPL(a_last_idle, m_tvalid && m_tlast, !busy, "shifter busy while last bit shown")

endmodule

### hw/rtl/two_digit_segment_display_driver_unit.sv
// top level of the two-digit seven-segment display driver
// depends on tdsd_pkg, tdsd_front, tdsd_queue and tdsd_shifter
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tuser: op; tdata: value, dot_on
// m_*      out  tvalid/tready      tdata: serial_bit; tlast: latch_now
// cfg_*    in   cfg_wen            cfg_wdata: blank_leading_zero
//
// every operation gives 16 output transfers; with m_tready held high words leave
// back to back, and the first bit of a word is registered into the queue entry and
// then into the shifter output register before it is offered, when the shifter is idle
// the front end takes an operation while the two-entry queue has room
// rst is synchronous and clears the segment bytes, blanking mode, queue and shifter
// a stall on m_tready holds the shifter; the front end keeps accepting until the queue fills
module two_digit_segment_display_driver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,  // blank_leading_zero
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] s_tuser,    // [1:0] op
  input  logic [7:0] s_tdata,    // [6:0] value, [7] dot_on
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [0] serial_bit, [7:1] zero
  output logic       m_tlast
);
  import tdsd_pkg::*;

  logic      push;
  seg_word_t push_word;
  logic      q_room;
  logic      pop;
  logic      q_valid;
  seg_word_t head;
  logic      out_bit;

  tdsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_word (push_word),
    .q_room    (q_room)
  );

  tdsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .q_room    (q_room),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  tdsd_shifter u_shifter (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_bit  (out_bit),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = {7'b0000000, out_bit};

endmodule
